[rtl/versatile_interface_adapter_core_defines.svh]
// Assertion macros for the interface adapter core.
// Used by the top level only; no dependencies.
`ifndef VERSATILE_INTERFACE_ADAPTER_CORE_DEFINES_SVH
`define VERSATILE_INTERFACE_ADAPTER_CORE_DEFINES_SVH
`define VIA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("via check failed");
`define VIA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("via check failed");
`endif

[rtl/via_pkg.sv]
// Shared types and constants for the interface adapter core.
// No dependencies.
package via_pkg;
  typedef enum logic [1:0] {
    MODE_READ = 2'd0, MODE_WRITE = 2'd1, MODE_TICK = 2'd2, MODE_EDGE = 2'd3
  } mode_t;
  localparam logic [3:0] R_ORB = 4'd0, R_ORA = 4'd1, R_DDRB = 4'd2, R_DDRA = 4'd3,
    R_T1CL = 4'd4, R_T1CH = 4'd5, R_T1LL = 4'd6, R_T1LH = 4'd7, R_T2L = 4'd8,
    R_T2H = 4'd9, R_SR = 4'd10, R_ACR = 4'd11, R_PCR = 4'd12, R_IFR = 4'd13,
    R_IER = 4'd14, R_ORA_NH = 4'd15;
  localparam logic [1:0] L_CA1 = 2'd0, L_CA2 = 2'd1, L_CB1 = 2'd2, L_CB2 = 2'd3;
  localparam int F_CA2 = 0, F_CA1 = 1, F_CB2 = 3, F_CB1 = 4, F_T2 = 5, F_T1 = 6;
  localparam logic [16:0] T1_MINUS_ONE = 17'h1ffff;
endpackage

[rtl/versatile_interface_adapter_core.sv]
// Interface adapter core: a 6522-style adapter with ports, timers and interrupts.
// Depends on via_pkg and versatile_interface_adapter_core_defines.svh.
//
// One item (bus read, bus write, tick or control edge) is accepted per cycle;
// its result appears in the output register in the next cycle, and the next
// item is taken only while the output register is free or being emptied.
// All state updates happen in the single accepting cycle.
`include "versatile_interface_adapter_core_defines.svh"
module versatile_interface_adapter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_port_b_pins,
  input  logic [1:0] in_edge_line,
  input  logic       in_edge_rising,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic [7:0] out_port_a_drive,
  output logic [7:0] out_port_b_drive,
  output logic       out_ca2_level,
  output logic       out_cb2_level,
  output logic       out_pb7_level
);
  import via_pkg::*;

  logic [7:0] ora_r, ddra_r, orb_r, ddrb_r, sr_r, acr_r, pcr_r;
  logic [15:0] t1l_r;
  logic [16:0] t1c_r, t2c_r;
  logic [7:0] t2ll_r;
  logic t1a_r, t2a_r, ca2_r, cb2_r, pb7_r;
  logic [6:0] ifr_r, ier_r;
  logic [7:0] ora_nxt, ddra_nxt, orb_nxt, ddrb_nxt, sr_nxt, acr_nxt, pcr_nxt;
  logic [15:0] t1l_nxt;
  logic [16:0] t1c_nxt, t2c_nxt;
  logic [7:0] t2ll_nxt, rd_nxt, bdrv;
  logic t1a_nxt, t2a_nxt, ca2_nxt, cb2_nxt, pb7_nxt;
  logic [6:0] ifr_nxt, ier_nxt;
  logic acc;
  logic ovalid_r;

  assign in_ready = !ovalid_r || out_ready;
  assign acc = in_valid && in_ready;
  assign out_valid = ovalid_r;

  always_comb begin
    logic [7:0] pbv;
    ora_nxt = ora_r; ddra_nxt = ddra_r; orb_nxt = orb_r; ddrb_nxt = ddrb_r;
    sr_nxt = sr_r; acr_nxt = acr_r; pcr_nxt = pcr_r; t1l_nxt = t1l_r;
    t1c_nxt = t1c_r; t2c_nxt = t2c_r; t2ll_nxt = t2ll_r; t1a_nxt = t1a_r;
    t2a_nxt = t2a_r; ca2_nxt = ca2_r; cb2_nxt = cb2_r; pb7_nxt = pb7_r;
    ifr_nxt = ifr_r; ier_nxt = ier_r; rd_nxt = 8'h00;
    pbv = (in_port_b_pins & ~ddrb_r) | (orb_r & ddrb_r);
    if (acr_r[7]) pbv[7] = pb7_r;
    unique case (mode_t'(in_mode))
      MODE_READ: begin
        unique case (in_reg_addr)
          R_ORB: begin
            rd_nxt = pbv; ifr_nxt[F_CB1] = 1'b0;
            if ((pcr_r & 8'ha0) != 8'h20) ifr_nxt[F_CB2] = 1'b0;
          end
          R_ORA: begin
            rd_nxt = in_port_a_pins; ifr_nxt[F_CA1] = 1'b0;
            if ((pcr_r & 8'h0a) != 8'h02) ifr_nxt[F_CA2] = 1'b0;
            if ((pcr_r & 8'h0c) == 8'h08) ca2_nxt = 1'b0;
          end
          R_DDRB: rd_nxt = ddrb_r;
          R_DDRA: rd_nxt = ddra_r;
          R_T1CL: begin rd_nxt = t1c_r[7:0]; ifr_nxt[F_T1] = 1'b0; end
          R_T1CH: rd_nxt = t1c_r[15:8];
          R_T1LL: rd_nxt = t1l_r[7:0];
          R_T1LH: rd_nxt = t1l_r[15:8];
          R_T2L: begin rd_nxt = t2c_r[7:0]; ifr_nxt[F_T2] = 1'b0; end
          R_T2H: rd_nxt = t2c_r[15:8];
          R_SR: rd_nxt = sr_r;
          R_ACR: rd_nxt = acr_r;
          R_PCR: rd_nxt = pcr_r;
          R_IFR: rd_nxt = {|(ifr_r & ier_r), ifr_r};
          R_IER: rd_nxt = {1'b1, ier_r};
          default: rd_nxt = in_port_a_pins;
        endcase
      end
      MODE_WRITE: begin
        unique case (in_reg_addr)
          R_ORB: begin
            ifr_nxt[F_CB1] = 1'b0;
            if ((pcr_r & 8'ha0) != 8'h20) ifr_nxt[F_CB2] = 1'b0;
            if ((pcr_r & 8'hc0) == 8'h80) cb2_nxt = 1'b0;
            orb_nxt = in_write_data;
          end
          R_ORA: begin
            ifr_nxt[F_CA1] = 1'b0;
            if ((pcr_r & 8'h0a) != 8'h02) ifr_nxt[F_CA2] = 1'b0;
            if ((pcr_r & 8'h0c) == 8'h08) ca2_nxt = 1'b0;
            ora_nxt = in_write_data;
          end
          R_DDRB: ddrb_nxt = in_write_data;
          R_DDRA: ddra_nxt = in_write_data;
          R_T1CL, R_T1LL: t1l_nxt[7:0] = in_write_data;
          R_T1CH: begin
            t1l_nxt[15:8] = in_write_data;
            t1c_nxt = {1'b0, in_write_data, t1l_r[7:0]};
            t1a_nxt = 1'b1; pb7_nxt = 1'b0; ifr_nxt[F_T1] = 1'b0;
          end
          R_T1LH: begin t1l_nxt[15:8] = in_write_data; ifr_nxt[F_T1] = 1'b0; end
          R_T2L: t2ll_nxt = in_write_data;
          R_T2H: begin
            t2c_nxt = {1'b0, in_write_data, t2ll_r};
            t2a_nxt = 1'b1; ifr_nxt[F_T2] = 1'b0;
          end
          R_SR: sr_nxt = in_write_data;
          R_ACR: begin
            if (in_write_data[7] && !acr_r[7]) pb7_nxt = 1'b1;
            acr_nxt = in_write_data;
          end
          R_PCR: begin
            ca2_nxt = !((in_write_data & 8'h0e) == 8'h0c);
            cb2_nxt = !((in_write_data & 8'he0) == 8'hc0);
            pcr_nxt = in_write_data;
          end
          R_IFR: ifr_nxt = ifr_r & ~in_write_data[6:0];
          R_IER: begin
            if (in_write_data[7]) ier_nxt = ier_r | in_write_data[6:0];
            else ier_nxt = ier_r & ~in_write_data[6:0];
          end
          default: ora_nxt = in_write_data;
        endcase
      end
      MODE_TICK: begin
        if (t1c_r == 17'd0) begin
          t1c_nxt = T1_MINUS_ONE;
          if (t1a_r) begin
            ifr_nxt[F_T1] = 1'b1;
            if (acr_r[6]) pb7_nxt = !pb7_r;
            else begin pb7_nxt = 1'b1; t1a_nxt = 1'b0; end
          end
        end else if (t1c_r == T1_MINUS_ONE) begin
          t1c_nxt = acr_r[6] ? {1'b0, t1l_r} : 17'h0fffe;
        end else begin
          t1c_nxt = {1'b0, t1c_r[15:0] - 16'd1};
        end
        if (t2c_r == 17'd0 && t2a_r) begin
          ifr_nxt[F_T2] = 1'b1; t2a_nxt = 1'b0;
        end
        t2c_nxt = {1'b0, t2c_r[15:0] - 16'd1};
        if ((pcr_r & 8'h0e) == 8'h0a) ca2_nxt = 1'b1;
        if ((pcr_r & 8'he0) == 8'ha0) cb2_nxt = 1'b1;
      end
      default: begin
        unique case (in_edge_line)
          L_CA1: if (in_edge_rising == pcr_r[0]) begin
            if ((pcr_r & 8'h0e) == 8'h08) ca2_nxt = 1'b1;
            ifr_nxt[F_CA1] = 1'b1;
          end
          L_CA2: if (!pcr_r[3] && in_edge_rising == pcr_r[2]) ifr_nxt[F_CA2] = 1'b1;
          L_CB1: if (in_edge_rising == pcr_r[4]) begin
            if ((pcr_r & 8'he0) == 8'h80) cb2_nxt = 1'b1;
            ifr_nxt[F_CB1] = 1'b1;
          end
          default: if (!pcr_r[7] && in_edge_rising == pcr_r[6]) ifr_nxt[F_CB2] = 1'b1;
        endcase
      end
    endcase
    bdrv = orb_nxt | ~ddrb_nxt;
    if (acr_nxt[7]) bdrv[7] = pb7_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ora_r <= 8'h00; ddra_r <= 8'h00; orb_r <= 8'h00; ddrb_r <= 8'h00;
      sr_r <= 8'h00; acr_r <= 8'h00; pcr_r <= 8'h00; t1l_r <= 16'hffff;
      t1c_r <= 17'h0ffff; t2c_r <= 17'h0ffff; t2ll_r <= 8'hff; t1a_r <= 1'b0;
      t2a_r <= 1'b0; ca2_r <= 1'b1; cb2_r <= 1'b1; pb7_r <= 1'b0;
      ifr_r <= 7'h00; ier_r <= 7'h00; ovalid_r <= 1'b0;
    end else begin
      if (acc) begin
        ora_r <= ora_nxt; ddra_r <= ddra_nxt; orb_r <= orb_nxt; ddrb_r <= ddrb_nxt;
        sr_r <= sr_nxt; acr_r <= acr_nxt; pcr_r <= pcr_nxt; t1l_r <= t1l_nxt;
        t1c_r <= t1c_nxt; t2c_r <= t2c_nxt; t2ll_r <= t2ll_nxt; t1a_r <= t1a_nxt;
        t2a_r <= t2a_nxt; ca2_r <= ca2_nxt; cb2_r <= cb2_nxt; pb7_r <= pb7_nxt;
        ifr_r <= ifr_nxt; ier_r <= ier_nxt;
      end
      if (acc) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // Result payload is captured with each accepted word.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_read_data <= rd_nxt;
      out_irq <= |(ifr_nxt & ier_nxt);
      out_port_a_drive <= ora_nxt | ~ddra_nxt;
      out_port_b_drive <= bdrv;
      out_ca2_level <= ca2_nxt;
      out_cb2_level <= cb2_nxt;
      out_pb7_level <= pb7_nxt;
    end
  end

  `VIA_ASSERT_IMPL(a_stall_holds, out_valid && !out_ready, !in_ready)
  `VIA_ASSERT_NEXT(a_acc_gives_out, acc, out_valid)
  `VIA_ASSERT_NEXT(a_irq_matches, acc, out_irq == (|(ifr_r & ier_r)))
endmodule
